// File: sv/crl_pkg.sv
// ----------------------------------------------------------------------------
// crl_pkg: shared types and constants for the client rate limiter
// Field widths, register indexes, action codes, table entry and control
// structures shared by the controller, datapath and configuration block.
// ----------------------------------------------------------------------------
package crl_pkg;

	localparam int CLIENT_COUNT = 64;
	localparam int CLIENT_W     = (CLIENT_COUNT > 1) ? $clog2(CLIENT_COUNT) : 1;
	localparam int CLIENT_IN_W  = 6;

	localparam int ACTION_W = 2;
	localparam int TOKIN_W  = 16;
	localparam int TIME_W   = 48;
	localparam int REQ_W    = 16;
	localparam int REQCNT_W = 17;
	localparam int TOK_W    = 24;
	localparam int ACT_W    = 8;
	localparam int WIN_W    = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// Action codes
	localparam logic [ACTION_W-1:0] ACT_ADMIT  = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_TCHECK = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_RECORD = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_REQUEST_LIMIT     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TOKEN_LIMIT       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CONCURRENCY_LIMIT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BURST_ENABLE      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BURST_ALLOWANCE   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH     = 3'd5;

	// Register reset values
	localparam logic [REQ_W-1:0] RST_REQUEST_LIMIT     = 16'd60;
	localparam logic [TOK_W-1:0] RST_TOKEN_LIMIT       = 24'd100000;
	localparam logic [ACT_W-1:0] RST_CONCURRENCY_LIMIT = 8'd4;
	localparam logic [REQ_W-1:0] RST_BURST_ALLOWANCE   = 16'd10;
	localparam logic [WIN_W-1:0] RST_WINDOW_LENGTH     = 32'd60000;

	typedef struct packed {
		logic [REQ_W-1:0] request_limit;
		logic [TOK_W-1:0] token_limit;
		logic [ACT_W-1:0] concurrency_limit;
		logic             burst_enable;
		logic [REQ_W-1:0] burst_allowance;
		logic [WIN_W-1:0] window_length_ms;
	} cfg_t;

	typedef struct packed {
		logic [TIME_W-1:0]   win_start;
		logic                started;
		logic [REQCNT_W-1:0] req_used;
		logic [TOK_W-1:0]    tok_used;
		logic [ACT_W-1:0]    active;
	} entry_t;

	// Controller to datapath commands, one per sequence step
	typedef struct packed {
		logic load;
		logic chk;
		logic upd;
		logic fin;
	} ctrl_cmd_t;

endpackage

// File: sv/crl_cfg.sv
// ----------------------------------------------------------------------------
// crl_cfg: configuration register file
// Holds the six limit registers, written through a plain indexed write port.
// ----------------------------------------------------------------------------
module crl_cfg import crl_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.request_limit     <= RST_REQUEST_LIMIT;
			cfg_q.token_limit       <= RST_TOKEN_LIMIT;
			cfg_q.concurrency_limit <= RST_CONCURRENCY_LIMIT;
			cfg_q.burst_enable      <= 1'b0;
			cfg_q.burst_allowance   <= RST_BURST_ALLOWANCE;
			cfg_q.window_length_ms  <= RST_WINDOW_LENGTH;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_REQUEST_LIMIT:     cfg_q.request_limit     <= cfg_wdata[REQ_W-1:0];
				REG_TOKEN_LIMIT:       cfg_q.token_limit       <= cfg_wdata[TOK_W-1:0];
				REG_CONCURRENCY_LIMIT: cfg_q.concurrency_limit <= cfg_wdata[ACT_W-1:0];
				REG_BURST_ENABLE:      cfg_q.burst_enable      <= cfg_wdata[0];
				REG_BURST_ALLOWANCE:   cfg_q.burst_allowance   <= cfg_wdata[REQ_W-1:0];
				REG_WINDOW_LENGTH:     cfg_q.window_length_ms  <= cfg_wdata[WIN_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: sv/crl_ctrl.sv
// ----------------------------------------------------------------------------
// crl_ctrl: sequence controller
// Steps one accepted beat through table read, window check, update and
// result formatting.
// ----------------------------------------------------------------------------
module crl_ctrl import crl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	output ctrl_cmd_t  cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHK,
		ST_UPD,
		ST_FIN
	} state_t;

	state_t state_q;
	logic   busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_CHK;
						busy_q  <= 1'b1;
					end
				end
				ST_CHK: state_q <= ST_UPD;
				ST_UPD: state_q <= ST_FIN;
				ST_FIN: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
				default: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	always_comb begin
		cmd.load = (state_q == ST_IDLE) && start;
		cmd.chk  = (state_q == ST_CHK);
		cmd.upd  = (state_q == ST_UPD);
		cmd.fin  = (state_q == ST_FIN);
	end

	assign busy = busy_q;

endmodule

// File: sv/crl_dp.sv
// ----------------------------------------------------------------------------
// crl_dp: client table and limit datapath
// Reads a client entry, restarts an expired window, applies the action,
// writes the entry back and formats the result beat.
// ----------------------------------------------------------------------------
module crl_dp import crl_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ctrl_cmd_t              cmd,
	input  cfg_t                   cfg,
	input  logic [ACTION_W-1:0]    action,
	input  logic [CLIENT_IN_W-1:0] client,
	input  logic [TOKIN_W-1:0]     tokens,
	input  logic [TIME_W-1:0]      now_ms,
	output logic                   done,
	output logic                   granted,
	output logic [REQ_W-1:0]       requests_remaining,
	output logic [TOK_W-1:0]       tokens_remaining,
	output logic [ACT_W-1:0]       active_count,
	output logic [TIME_W-1:0]      window_end_ms
);

	entry_t              tbl_mem [CLIENT_COUNT];
	logic [CLIENT_COUNT-1:0] valid_q;

	logic [ACTION_W-1:0] action_q;
	logic [CLIENT_W-1:0] idx_q;
	logic                in_range_q;
	logic [TOKIN_W-1:0]  tok_q;
	logic [TIME_W-1:0]   now_q;
	entry_t              rd_q;
	logic                rd_valid_q;
	logic                restart_q;
	entry_t              new_q;
	logic                granted_q;

	logic                done_q;
	logic                out_granted_q;
	logic [REQ_W-1:0]    out_req_q;
	logic [TOK_W-1:0]    out_tok_q;
	logic [ACT_W-1:0]    out_act_q;
	logic [TIME_W-1:0]   out_wend_q;

	logic [CLIENT_W-1:0] in_idx;
	logic                in_range;
	entry_t              ent;
	logic [TIME_W-1:0]   elapsed;
	logic                is_window_op;
	entry_t              cur;
	entry_t              nxt;
	logic                grant;
	logic [REQCNT_W-1:0] req_cap;
	logic                req_ok;
	logic [TOK_W:0]      tok_sum;
	logic [REQCNT_W-1:0] req_lim_x;

	assign in_idx   = CLIENT_W'(client);
	assign in_range = ({1'b0, client} < (CLIENT_IN_W+1)'(CLIENT_COUNT));

	// Capture the beat and read the entry
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q   <= action;
			idx_q      <= in_idx;
			in_range_q <= in_range;
			tok_q      <= tokens;
			now_q      <= now_ms;
			rd_q       <= tbl_mem[in_idx];
			rd_valid_q <= valid_q[in_idx];
		end
	end

	// Window expiry check
	assign ent          = rd_valid_q ? rd_q : '0;
	assign elapsed      = now_q - ent.win_start;
	assign is_window_op = (action_q == ACT_ADMIT) || (action_q == ACT_TCHECK);

	always_ff @(posedge clk) begin
		if (cmd.chk) begin
			restart_q <= is_window_op &&
				(!ent.started || (elapsed >= TIME_W'(cfg.window_length_ms)));
		end
	end

	// Apply the action
	assign req_lim_x = REQCNT_W'(cfg.request_limit);
	assign req_cap   = req_lim_x + REQCNT_W'(cfg.burst_allowance);

	always_comb begin
		cur = ent;
		if (restart_q) begin
			cur.win_start = now_q;
			cur.started   = 1'b1;
			cur.req_used  = '0;
			cur.tok_used  = '0;
		end
		nxt     = cur;
		grant   = 1'b0;
		req_ok  = (cur.req_used < req_lim_x) ||
			(cfg.burst_enable && (cur.req_used < req_cap));
		tok_sum = (TOK_W+1)'(cur.tok_used) + (TOK_W+1)'(tok_q);
		case (action_q)
			ACT_ADMIT: begin
				if ((cur.active < cfg.concurrency_limit) && req_ok) begin
					nxt.req_used = cur.req_used + 1'b1;
					nxt.active   = cur.active + 1'b1;
					grant        = 1'b1;
				end
			end
			ACT_TCHECK: begin
				grant = (tok_sum <= (TOK_W+1)'(cfg.token_limit));
			end
			ACT_RECORD: begin
				nxt.tok_used = tok_sum[TOK_W] ? {TOK_W{1'b1}} : tok_sum[TOK_W-1:0];
				if (cur.active != '0) begin
					nxt.active = cur.active - 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.upd) begin
			new_q     <= nxt;
			granted_q <= grant;
			if (in_range_q) begin
				tbl_mem[idx_q] <= nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.upd && in_range_q) begin
			valid_q[idx_q] <= 1'b1;
		end
	end

	// Format the result beat
	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			if (in_range_q) begin
				out_granted_q <= granted_q;
				out_req_q     <= (req_lim_x > new_q.req_used) ?
					REQ_W'(req_lim_x - new_q.req_used) : '0;
				out_tok_q     <= (cfg.token_limit > new_q.tok_used) ?
					(cfg.token_limit - new_q.tok_used) : '0;
				out_act_q     <= new_q.active;
				out_wend_q    <= new_q.win_start + TIME_W'(cfg.window_length_ms);
			end else begin
				out_granted_q <= 1'b0;
				out_req_q     <= '0;
				out_tok_q     <= '0;
				out_act_q     <= '0;
				out_wend_q    <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.fin;
		end
	end

	assign done               = done_q;
	assign granted            = out_granted_q;
	assign requests_remaining = out_req_q;
	assign tokens_remaining   = out_tok_q;
	assign active_count       = out_act_q;
	assign window_end_ms      = out_wend_q;

endmodule

// File: sv/client_rate_limiter.sv
// ----------------------------------------------------------------------------
// client_rate_limiter: per-client fixed-window rate limiter with burst
// Admits requests, checks token budgets, records token use and releases active slots per client.
// ----------------------------------------------------------------------------
// A beat is taken when start is high while busy is low. Its result appears
// on the result ports after the table read, window check, update and
// formatting steps and stays for exactly one cycle, flagged by done; the
// receiver cannot stall it, so capture it in that cycle. busy stays high
// until the result is registered, so a new beat is taken only after the
// last one has finished. The steps follow the client table: a registered
// read, a window expiry check, the counter update with its write back, and
// the registered formatting of the remaining counts. The table starts
// cleared after reset through per-client valid bits, so no clearing pass is
// needed and start is honored from the first cycle. Write the limit
// registers only while the block is idle.
module client_rate_limiter import crl_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	// command channel
	input  logic                   start,
	output logic                   busy,
	input  logic [ACTION_W-1:0]    action,
	input  logic [CLIENT_IN_W-1:0] client,
	input  logic [TOKIN_W-1:0]     tokens,
	input  logic [TIME_W-1:0]      now_ms,
	// result channel
	output logic                   done,
	output logic                   granted,
	output logic [REQ_W-1:0]       requests_remaining,
	output logic [TOK_W-1:0]       tokens_remaining,
	output logic [ACT_W-1:0]       active_count,
	output logic [TIME_W-1:0]      window_end_ms,
	// configuration write port
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_idx,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

	cfg_t      cfg;
	ctrl_cmd_t cmd;

	// Limit registers
	crl_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// Sequencer: idle, check, update, finish
	crl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	// Client table and arithmetic
	crl_dp u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.cfg                (cfg),
		.action             (action),
		.client             (client),
		.tokens             (tokens),
		.now_ms             (now_ms),
		.done               (done),
		.granted            (granted),
		.requests_remaining (requests_remaining),
		.tokens_remaining   (tokens_remaining),
		.active_count       (active_count),
		.window_end_ms      (window_end_ms)
	);

endmodule
